### design/sahc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sahc_pkg
// shared types, codes and sizes of the store access hazard checker
// ----------------------------------------------------------------------------
package sahc_pkg;

  localparam int STORE_SLOTS = 256;
  localparam int SLOT_BITS   = $clog2(STORE_SLOTS);
  localparam int MAX_DIMS    = 4;
  localparam int EXTENT_BITS = 16;
  localparam int SHAPE_BITS  = 64;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  localparam int IN_DATA_BITS  = 152;
  localparam int OUT_DATA_BITS = 8;

  // access modes
  localparam logic [1:0] MODE_READ   = 2'd0;
  localparam logic [1:0] MODE_WRITE  = 2'd1;
  localparam logic [1:0] MODE_REDUCE = 2'd2;

  // partition kinds
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_TILING = 2'd1;

  // verdicts
  localparam logic [3:0] VERDICT_PASS      = 4'd0;
  localparam logic [3:0] VERDICT_SKIP      = 4'd1;
  localparam logic [3:0] VERDICT_FAIL_BASE = 4'd2;

  // one classified access as it travels from front to back
  typedef struct packed {
    logic                  first_of_op;
    logic [SLOT_BITS-1:0]  slot;
    logic [1:0]            mode;
    logic [1:0]            kind;
    logic [2:0]            dims;
    logic [SHAPE_BITS-1:0] tile;
    logic [SHAPE_BITS-1:0] color;
    logic                  scalar;
    logic                  single;
  } item_t;

  // one table entry
  typedef struct packed {
    logic [1:0]            mode;
    logic [1:0]            kind;
    logic [2:0]            dims;
    logic [SHAPE_BITS-1:0] tile;
    logic [SHAPE_BITS-1:0] color;
  } entry_t;

  // result beat contents
  typedef struct packed {
    logic [3:0] verdict;
    logic       op_failed;
  } result_t;

endpackage

### design/store_access_hazard_checker_unit.sv
`timescale 1ns / 1ps
// a beat passes the front register, the queue, the table fetch and the result register before m_axis_tvalid
// the back end takes a new access only once it is through with the last one: it fetches,
//   then evaluates and updates, so the next table read always sees the previous update
// the front register and a four-deep queue keep taking beats while the back end waits
// reset: asynchronous, active low; clears all table valid bits, the sticky failure,
//   the queue and both handshakes at once, no clearing pass
// ----------------------------------------------------------------------------
// store_access_hazard_checker_unit
// checks each store access of an operation against the last passed access recorded
// on the same store and reports pass, skip or the hazard kind
// ----------------------------------------------------------------------------
module store_access_hazard_checker_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input beat
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // from bit 0 up: first_of_op(1), store_id(8), mode(2), part_kind(2),
  // shape_dims(3), tile_ext(64), color_ext(64), store_is_scalar(1),
  // launch_is_single(1), zero fill(6)
  input  logic [sahc_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
  // result beat
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // from bit 0 up: verdict(4), op_failed(1), zero fill(3)
  output logic [sahc_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata
);

  // front to queue
  logic              push;
  logic              full;
  sahc_pkg::item_t   front_item;

  // queue to back
  logic              pop;
  logic              empty;
  sahc_pkg::item_t   back_item;

  sahc_pkg::result_t result;

  // front: register the beat, wrap the id, fold mode 3 into reduce
  sahc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .push_o     (push),
    .full_i     (full),
    .item_o     (front_item)
  );

  // decoupling queue so either side can stall on its own
  sahc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (front_item),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_item_o  (back_item)
  );

  // back: table fetch, hazard check, update, result register
  sahc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .item_i      (back_item),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (result)
  );

  assign m_axis_tdata = {3'b000, result.op_failed, result.verdict};

endmodule

### design/sahc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sahc_front
// input stage: takes beats, unpacks and classifies them, feeds the queue
// ----------------------------------------------------------------------------
module sahc_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [sahc_pkg::IN_DATA_BITS-1:0]     in_data_i,
  output logic                                  push_o,
  input  logic                                  full_i,
  output sahc_pkg::item_t                       item_o
);

  logic            valid_q, valid_d;
  sahc_pkg::item_t item_q;
  sahc_pkg::item_t item_c;
  logic [1:0]      mode_raw;

  assign mode_raw = in_data_i[10:9];

  // unpack, wrap the store id onto the table, fold the unused mode into reduce
  always_comb begin
    item_c.first_of_op = in_data_i[0];
    item_c.slot        = sahc_pkg::SLOT_BITS'(in_data_i[8:1]);
    item_c.mode        = (mode_raw == sahc_pkg::MODE_READ ||
                          mode_raw == sahc_pkg::MODE_WRITE) ? mode_raw
                                                            : sahc_pkg::MODE_REDUCE;
    item_c.kind        = in_data_i[12:11];
    item_c.dims        = in_data_i[15:13];
    item_c.tile        = in_data_i[79:16];
    item_c.color       = in_data_i[143:80];
    item_c.scalar      = in_data_i[144];
    item_c.single      = in_data_i[145];
  end

  assign push_o     = valid_q && !full_i;
  assign in_ready_o = !valid_q || !full_i;
  assign item_o     = item_q;

  always_comb begin
    valid_d = valid_q;
    if (push_o) begin
      valid_d = 1'b0;
    end
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_c;
    end
  end

endmodule

### design/sahc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sahc_queue
// short fifo of classified accesses between front and back
// ----------------------------------------------------------------------------
module sahc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sahc_pkg::item_t push_item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output sahc_pkg::item_t pop_item_o
);

  localparam int CntBits = $clog2(sahc_pkg::QUEUE_DEPTH + 1);

  sahc_pkg::item_t                    slots_q [sahc_pkg::QUEUE_DEPTH];
  logic [sahc_pkg::QPTR_BITS-1:0]     wptr_q, wptr_d;
  logic [sahc_pkg::QPTR_BITS-1:0]     rptr_q, rptr_d;
  logic [CntBits-1:0]                 count_q, count_d;

  assign full_o     = (count_q == CntBits'(sahc_pkg::QUEUE_DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_item_o = slots_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (wptr_q == sahc_pkg::QPTR_BITS'(sahc_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == sahc_pkg::QPTR_BITS'(sahc_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wptr_q] <= push_item_i;
    end
  end

endmodule

### design/sahc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sahc_back
// table read, hazard check, table update and result register
// ----------------------------------------------------------------------------
module sahc_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 empty_i,
  input  sahc_pkg::item_t                      item_i,
  output logic                                 pop_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output sahc_pkg::result_t                    result_o
);

  localparam logic ST_FETCH = 1'b0;
  localparam logic ST_EVAL  = 1'b1;

  logic state_q, state_d;

  sahc_pkg::entry_t  table_mem [sahc_pkg::STORE_SLOTS];
  logic [sahc_pkg::STORE_SLOTS-1:0] valid_q;
  sahc_pkg::entry_t  rd_q;
  logic              rd_valid_q;
  sahc_pkg::item_t   cur_q;

  logic              out_valid_q, out_valid_d;
  sahc_pkg::result_t result_q, result_d;
  logic              failed_q, failed_d;

  logic              out_free;
  logic              failed_eff;
  logic              tile_eq, color_eq, part_eq;
  logic              do_write;
  logic [3:0]        fail_code;

  assign out_free    = !out_valid_q || out_ready_i;
  assign pop_o       = (state_q == ST_FETCH) && !empty_i && out_free;
  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  // extents beyond the dimension count are ignored
  always_comb begin
    tile_eq  = 1'b1;
    color_eq = 1'b1;
    for (int i = 0; i < sahc_pkg::MAX_DIMS; i++) begin
      if (3'(i) < cur_q.dims) begin
        if (rd_q.tile[i*sahc_pkg::EXTENT_BITS +: sahc_pkg::EXTENT_BITS] !=
            cur_q.tile[i*sahc_pkg::EXTENT_BITS +: sahc_pkg::EXTENT_BITS]) begin
          tile_eq = 1'b0;
        end
        if (rd_q.color[i*sahc_pkg::EXTENT_BITS +: sahc_pkg::EXTENT_BITS] !=
            cur_q.color[i*sahc_pkg::EXTENT_BITS +: sahc_pkg::EXTENT_BITS]) begin
          color_eq = 1'b0;
        end
      end
    end
  end

  always_comb begin
    part_eq = 1'b0;
    if (rd_q.kind == cur_q.kind) begin
      case (cur_q.kind)
        sahc_pkg::KIND_NONE:   part_eq = 1'b1;
        sahc_pkg::KIND_TILING: part_eq = (rd_q.dims == cur_q.dims) && tile_eq && color_eq;
        default:               part_eq = 1'b0;
      endcase
    end
  end

  assign fail_code = sahc_pkg::VERDICT_FAIL_BASE + 4'(cur_q.mode) * 4'd3 + 4'(rd_q.mode);
  assign failed_eff = failed_q && !cur_q.first_of_op;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    result_d    = result_q;
    failed_d    = failed_q;
    do_write    = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_FETCH: begin
        if (pop_o) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_d     = ST_FETCH;
        out_valid_d = 1'b1;
        failed_d    = failed_eff;
        if (failed_eff) begin
          result_d.verdict = sahc_pkg::VERDICT_SKIP;
        end else if (!rd_valid_q) begin
          result_d.verdict = sahc_pkg::VERDICT_PASS;
          do_write         = 1'b1;
        end else if (rd_q.mode == sahc_pkg::MODE_REDUCE) begin
          // read of a one-element store from a single-point launch passes untouched
          if (cur_q.mode == sahc_pkg::MODE_READ && cur_q.scalar && cur_q.single) begin
            result_d.verdict = sahc_pkg::VERDICT_PASS;
          end else begin
            result_d.verdict = fail_code;
            failed_d         = 1'b1;
          end
        end else if (part_eq) begin
          result_d.verdict = sahc_pkg::VERDICT_PASS;
          do_write         = 1'b1;
        end else begin
          result_d.verdict = fail_code;
          failed_d         = 1'b1;
        end
        result_d.op_failed = failed_d;
      end
      default: state_d = ST_FETCH;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FETCH;
      out_valid_q <= 1'b0;
      failed_q    <= 1'b0;
      valid_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      failed_q    <= failed_d;
      if (do_write) begin
        valid_q[cur_q.slot] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
    if (pop_o) begin
      cur_q      <= item_i;
      rd_valid_q <= valid_q[item_i.slot];
    end
  end

  // table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (do_write) begin
      table_mem[cur_q.slot] <= '{mode:  cur_q.mode,
                                 kind:  cur_q.kind,
                                 dims:  cur_q.dims,
                                 tile:  cur_q.tile,
                                 color: cur_q.color};
    end
    if (pop_o) begin
      rd_q <= table_mem[item_i.slot];
    end
  end

endmodule
